>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by the table core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/ecdt_pkg.sv
// ----------------------------------------------------------------------------
// ecdt_pkg
// Types and constants of the event coalescing debounce table.
// ----------------------------------------------------------------------------
package ecdt_pkg;
    localparam int TableDepth = 16;
    localparam int IdxBits    = 4;
    localparam int KeyBits    = 16;
    localparam int TimeBits   = 32;
    localparam int CntBits    = 5;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_DRAIN = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] EV_CREATED  = 3'd0;
    localparam logic [2:0] EV_MODIFIED = 3'd1;
    localparam logic [2:0] EV_DELETED  = 3'd2;
    localparam logic [2:0] EV_RENAMED  = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_MERGED    = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_EMITTED   = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] key;
        logic [2:0]  event_type;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_key;
        logic [2:0]  out_type;
        logic        last;
        logic [4:0]  pend_cnt;
        logic [31:0] wait_ticks;
    } out_item_t;

    // Ticks still to wait for an entry, zero once settled.
    function automatic logic [TimeBits-1:0] remain_ticks(
        input logic [TimeBits-1:0] now_v,
        input logic [TimeBits-1:0] act_v,
        input logic [TimeBits-1:0] deb_v);
        logic [TimeBits-1:0] el;
        el = now_v - act_v;
        return (el >= deb_v) ? '0 : (deb_v - el);
    endfunction
endpackage

>>> design/event_coalescing_debounce_table_core.sv
// An add gives its result after a key scan walk, an apply step and a summary walk;
// a clear gives it without a table walk; mode three gives none.
// A drain does one scan walk per emitted entry, one more that finds none, then a
// summary walk before the final row. One item at a time: the next transfer is taken the
// cycle after the final result is loaded, once the output register is free.
// Reset clears valid bits and sets debounce_ticks to 100; slot payloads are undefined.
// ----------------------------------------------------------------------------
// event_coalescing_debounce_table_core
// Keyed debounce table that coalesces change events and drains settled ones.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module event_coalescing_debounce_table_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ecdt_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ecdt_pkg::out_item_t  out_data
);
    import ecdt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_APPLY = 8'b0000_0100,
        S_SUMM  = 8'b0000_1000,
        S_OUT   = 8'b0001_0000,
        S_EMIT  = 8'b0010_0000,
        S_HOLD  = 8'b0100_0000,
        S_WAITO = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [31:0]           deb_reg;
    in_item_t              item_reg;
    logic [TableDepth-1:0] valid_reg;
    logic [IdxBits-1:0]    ptr_reg;       // slot pointer of the walk
    logic                  phase_reg;     // 0 issue read, 1 use data
    logic                  hit_found_reg, free_found_reg, best_found_reg;
    logic [IdxBits-1:0]    hit_idx_reg, free_idx_reg, best_idx_reg;
    logic [KeyBits-1:0]    best_key_reg;
    logic [2:0]            best_type_reg;
    logic [KeyBits-1:0]    park_key_reg;
    logic [2:0]            park_type_reg;
    logic                  any_emit_reg;
    logic [CntBits-1:0]    cnt_reg;
    logic [TimeBits-1:0]   wmin_reg;
    logic [2:0]            stat_reg;
    logic [2:0]            hit_first_reg;
    logic                  pend_emit_reg;
    out_item_t             out_reg;
    logic                  out_valid_reg;

    logic [IdxBits-1:0]    rd_idx;
    logic [KeyBits-1:0]    rd_key;
    logic [2:0]            rd_first, rd_latest;
    logic [TimeBits-1:0]   rd_time;
    logic                  wr_en;
    logic [IdxBits-1:0]    wr_idx;
    logic [2:0]            wr_first, wr_latest;
    logic [TimeBits-1:0]   wr_time;
    logic [2:0]            ev_t;
    logic [TimeBits-1:0]   rem;
    logic [IdxBits-1:0]    cur_idx;
    logic                  scan_done;
    logic                  out_load;

    ecdt_slot_ram u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_key    (item_reg.key),
        .wr_first  (wr_first),
        .wr_latest (wr_latest),
        .wr_time   (wr_time),
        .rd_idx    (rd_idx),
        .rd_key    (rd_key),
        .rd_first  (rd_first),
        .rd_latest (rd_latest),
        .rd_time   (rd_time)
    );

    assign ev_t      = (item_reg.event_type > EV_ERROR) ? EV_ERROR : item_reg.event_type;
    assign cur_idx   = ptr_reg;
    assign rd_idx    = cur_idx;
    assign scan_done = (ptr_reg == IdxBits'(TableDepth - 1)) && phase_reg;
    // Shared compare unit: remaining ticks of the slot just read.
    assign rem       = remain_ticks(item_reg.now, rd_time, deb_reg);

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The output register is loaded with a non-last emitted row or with the final row.
    assign out_load = (!out_valid_reg || out_ready) &&
                      ((state_reg == S_WAITO) ||
                       (state_reg == S_HOLD && pend_emit_reg && any_emit_reg));

    // Table update for an add, decided from the scan result.
    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = hit_found_reg ? hit_idx_reg : free_idx_reg;
        wr_first  = ev_t;
        wr_latest = ev_t;
        wr_time   = (ev_t >= EV_OVERFLOW) ? (item_reg.now - deb_reg) : item_reg.now;
        if (state_reg == S_APPLY)
        begin
            if (!hit_found_reg)
                wr_en = free_found_reg;
            else if (ev_t >= EV_OVERFLOW)
                wr_en = 1'b1;
            else if (!(hit_first_reg == EV_CREATED && ev_t == EV_DELETED))
            begin
                wr_en = 1'b1;
                if (hit_first_reg == EV_DELETED &&
                    (ev_t == EV_CREATED || ev_t == EV_MODIFIED))
                begin
                    wr_first  = EV_MODIFIED;
                    wr_latest = EV_MODIFIED;
                end
                else
                begin
                    wr_latest = ev_t;
                    if (ev_t == EV_DELETED || ev_t == EV_RENAMED)
                        wr_first = ev_t;
                    else
                        wr_first = hit_first_reg;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid && in_ready)
                     begin
                         case (in_data.mode)
                             MODE_ADD:   state_next = S_SCAN;
                             MODE_DRAIN: state_next = S_SCAN;
                             MODE_CLEAR: state_next = S_OUT;
                             default:    state_next = S_IDLE;
                         endcase
                     end
            S_SCAN:  if (scan_done)
                         state_next = (item_reg.mode == MODE_ADD) ? S_APPLY : S_EMIT;
            S_APPLY: state_next = S_SUMM;
            S_SUMM:  if (scan_done) state_next = S_OUT;
            S_EMIT:  state_next = S_HOLD;
            S_HOLD:  if (!out_valid_reg || out_ready)
                         state_next = pend_emit_reg ? S_SCAN : S_SUMM;
            S_OUT:   state_next = S_WAITO;
            S_WAITO: if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Result valid flag: set on a load, cleared when the waiting row is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            deb_reg       <= 32'd100;
            valid_reg     <= '0;
            ptr_reg       <= '0;
            phase_reg     <= 1'b0;
            pend_emit_reg <= 1'b0;
            any_emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        deb_reg <= cfg_data;
                    if (in_valid)
                    begin
                        item_reg       <= in_data;
                        ptr_reg        <= '0;
                        phase_reg      <= 1'b0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        best_found_reg <= 1'b0;
                        any_emit_reg   <= 1'b0;
                        cnt_reg        <= '0;
                        wmin_reg       <= '1;
                        if (in_data.mode == MODE_CLEAR)
                        begin
                            valid_reg <= '0;
                            stat_reg  <= ST_CLEARED;
                        end
                    end
                end
                S_SCAN, S_SUMM:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        ptr_reg <= scan_done ? '0 : ptr_reg + 1'b1;
                        if (state_reg == S_SUMM)
                        begin
                            if (valid_reg[cur_idx])
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                                if (rem < wmin_reg)
                                    wmin_reg <= rem;
                            end
                        end
                        else if (item_reg.mode == MODE_ADD)
                        begin
                            if (valid_reg[cur_idx] && rd_key == item_reg.key)
                            begin
                                hit_found_reg  <= 1'b1;
                                hit_idx_reg    <= cur_idx;
                                hit_first_reg  <= rd_first;
                            end
                            else if (!valid_reg[cur_idx] && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= cur_idx;
                            end
                        end
                        else if (valid_reg[cur_idx] && rem == '0 &&
                                 (!best_found_reg || rd_key < best_key_reg))
                        begin
                            best_found_reg <= 1'b1;
                            best_idx_reg   <= cur_idx;
                            best_key_reg   <= rd_key;
                            best_type_reg  <= (rd_first == EV_CREATED &&
                                               rd_latest == EV_MODIFIED)
                                              ? EV_CREATED : rd_latest;
                        end
                    end
                end
                S_APPLY:
                begin
                    if (!hit_found_reg)
                    begin
                        stat_reg <= free_found_reg ? ST_NEW : ST_DROPPED;
                        if (free_found_reg)
                            valid_reg[free_idx_reg] <= 1'b1;
                    end
                    else if (ev_t < EV_OVERFLOW && hit_first_reg == EV_CREATED &&
                             ev_t == EV_DELETED)
                    begin
                        stat_reg <= ST_CANCELLED;
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    else
                        stat_reg <= ST_MERGED;
                end
                S_EMIT:
                begin
                    // The found entry goes out after the next scan or in the final row.
                    pend_emit_reg <= best_found_reg;
                    if (best_found_reg)
                        valid_reg[best_idx_reg] <= 1'b0;
                end
                S_HOLD:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        if (pend_emit_reg)
                        begin
                            // A new winner proves the parked one is not last, so the
                            // parked one goes out and the new one takes its place.
                            any_emit_reg   <= 1'b1;
                            best_found_reg <= 1'b0;
                            park_key_reg   <= best_key_reg;
                            park_type_reg  <= best_type_reg;
                            if (any_emit_reg)
                            begin
                                out_reg.status     <= ST_EMITTED;
                                out_reg.out_key    <= park_key_reg;
                                out_reg.out_type   <= park_type_reg;
                                out_reg.last       <= 1'b0;
                                out_reg.pend_cnt   <= '0;
                                out_reg.wait_ticks <= '0;
                            end
                        end
                        else
                            stat_reg <= any_emit_reg ? ST_EMITTED : ST_NONE;
                    end
                end
                S_WAITO:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.status       <= stat_reg;
                        out_reg.last         <= 1'b1;
                        if (item_reg.mode == MODE_CLEAR)
                        begin
                            out_reg.pend_cnt   <= '0;
                            out_reg.wait_ticks <= '1;
                        end
                        else
                        begin
                            out_reg.pend_cnt   <= cnt_reg;
                            out_reg.wait_ticks <= wmin_reg;
                        end
                        if (item_reg.mode == MODE_ADD)
                        begin
                            out_reg.out_key  <= item_reg.key;
                            out_reg.out_type <= ev_t;
                        end
                        else if (stat_reg == ST_EMITTED)
                        begin
                            out_reg.out_key  <= park_key_reg;
                            out_reg.out_type <= park_type_reg;
                        end
                        else
                        begin
                            out_reg.out_key  <= '0;
                            out_reg.out_type <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, (state_reg != S_IDLE), !in_ready)
    `ASSERT_NEXT(a_out_holds, (out_valid && !out_ready), out_valid && $stable(out_data))
    `ASSERT_IMPL(a_count_range, (state_reg == S_OUT), cnt_reg <= CntBits'(TableDepth))
endmodule

>>> design/ecdt_slot_ram.sv
// ----------------------------------------------------------------------------
// ecdt_slot_ram
// Slot payload store: key, first type, latest type and activity time.
// ----------------------------------------------------------------------------
module ecdt_slot_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ecdt_pkg::IdxBits-1:0] wr_idx,
    input  logic [ecdt_pkg::KeyBits-1:0] wr_key,
    input  logic [2:0]                   wr_first,
    input  logic [2:0]                   wr_latest,
    input  logic [ecdt_pkg::TimeBits-1:0] wr_time,
    input  logic [ecdt_pkg::IdxBits-1:0] rd_idx,
    output logic [ecdt_pkg::KeyBits-1:0] rd_key,
    output logic [2:0]                   rd_first,
    output logic [2:0]                   rd_latest,
    output logic [ecdt_pkg::TimeBits-1:0] rd_time
);
    import ecdt_pkg::*;

    logic [KeyBits-1:0]  key_mem   [TableDepth];
    logic [2:0]          first_mem [TableDepth];
    logic [2:0]          lat_mem   [TableDepth];
    logic [TimeBits-1:0] time_mem  [TableDepth];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx]   <= wr_key;
            first_mem[wr_idx] <= wr_first;
            lat_mem[wr_idx]   <= wr_latest;
            time_mem[wr_idx]  <= wr_time;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_key    <= key_mem[rd_idx];
        rd_first  <= first_mem[rd_idx];
        rd_latest <= lat_mem[rd_idx];
        rd_time   <= time_mem[rd_idx];
    end
endmodule
